@@ sv/forth_data_stack_unit_macros.svh @@
// assertion helpers for the stack unit
`ifndef FORTH_DATA_STACK_UNIT_MACROS_SVH
`define FORTH_DATA_STACK_UNIT_MACROS_SVH

// same-cycle implication
`define FDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ sv/fds_pkg.sv @@
package fds_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int WORD_WIDTH_DEF  = 32;
	localparam int CMD_W           = 5;
	localparam int LIMIT_W         = 7;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
	localparam logic REG_STACK_LIMIT = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH   = 5'd0,
		CMD_DROP   = 5'd1,
		CMD_DUP    = 5'd2,
		CMD_SWAP   = 5'd3,
		CMD_OVER   = 5'd4,
		CMD_ROT    = 5'd5,
		CMD_2SWAP  = 5'd6,
		CMD_2DUP   = 5'd7,
		CMD_2OVER  = 5'd8,
		CMD_2DROP  = 5'd9,
		CMD_2ROT   = 5'd10,
		CMD_ADD    = 5'd11,
		CMD_SUB    = 5'd12,
		CMD_MUL    = 5'd13,
		CMD_DIV    = 5'd14,
		CMD_MOD    = 5'd15,
		CMD_DIVMOD = 5'd16,
		CMD_EQ     = 5'd17,
		CMD_LT     = 5'd18,
		CMD_GT     = 5'd19,
		CMD_INV    = 5'd20,
		CMD_AND    = 5'd21,
		CMD_OR     = 5'd22,
		CMD_DEPTH  = 5'd23
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	typedef struct packed {
		logic       known;
		logic       is_div;
		logic       is_md;
		logic [2:0] need;
		logic [2:0] pops;
		logic [2:0] npush;
	} dec_t;

	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_ctl_t;

	function automatic dec_t decode(input logic [CMD_W-1:0] c);
		dec_t d;
		d = '{known: 1'b1, is_div: 1'b0, is_md: 1'b0, need: 3'd0, pops: 3'd0, npush: 3'd0};
		unique case (c)
			CMD_PUSH:  d.npush = 3'd1;
			CMD_DROP:  begin d.need = 3'd1; d.pops = 3'd1; end
			CMD_DUP:   begin d.need = 3'd1; d.npush = 3'd1; end
			CMD_SWAP:  begin d.need = 3'd2; d.pops = 3'd2; d.npush = 3'd2; end
			CMD_OVER:  begin d.need = 3'd2; d.npush = 3'd1; end
			CMD_ROT:   begin d.need = 3'd3; d.pops = 3'd3; d.npush = 3'd3; end
			CMD_2SWAP: begin d.need = 3'd4; d.pops = 3'd4; d.npush = 3'd4; end
			CMD_2DUP:  begin d.need = 3'd2; d.npush = 3'd2; end
			CMD_2OVER: begin d.need = 3'd4; d.npush = 3'd2; end
			CMD_2DROP: begin d.need = 3'd2; d.pops = 3'd2; end
			CMD_2ROT:  begin d.need = 3'd6; d.pops = 3'd6; d.npush = 3'd6; end
			CMD_ADD, CMD_SUB, CMD_EQ, CMD_LT, CMD_GT, CMD_AND, CMD_OR: begin
				d.need = 3'd2; d.pops = 3'd2; d.npush = 3'd1;
			end
			CMD_MUL: begin
				d.need = 3'd2; d.pops = 3'd2; d.npush = 3'd1; d.is_md = 1'b1;
			end
			CMD_DIV, CMD_MOD: begin
				d.need = 3'd2; d.pops = 3'd2; d.npush = 3'd1;
				d.is_md = 1'b1; d.is_div = 1'b1;
			end
			CMD_DIVMOD: begin
				d.need = 3'd2; d.pops = 3'd2; d.npush = 3'd2;
				d.is_md = 1'b1; d.is_div = 1'b1;
			end
			CMD_INV:   begin d.need = 3'd1; d.pops = 3'd1; d.npush = 3'd1; end
			CMD_DEPTH: d.npush = 3'd1;
			default:   d.known = 1'b0;
		endcase
		return d;
	endfunction

endpackage

@@ sv/fds_ram.sv @@
module fds_ram
	import fds_pkg::*;
#(
	parameter int DEPTH = STACK_DEPTH_DEF,
	parameter int W     = WORD_WIDTH_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ sv/fds_mdu.sv @@
module fds_mdu
	import fds_pkg::*;
#(
	parameter int W = WORD_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  mdu_ctl_t     ctl,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic         done,
	output logic [W-1:0] prod,
	output logic [W-1:0] quo,
	output logic [W-1:0] rem
);

	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic          is_div_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  r_q;
	logic          negq_q;
	logic          negr_q;
	logic [W:0]    trial;

	assign trial = {r_q, x_q[W-1]} - {1'b0, y_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == CW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			is_div_q <= ctl.is_div;
			cnt_q    <= '0;
			acc_q    <= '0;
			r_q      <= '0;
			if (ctl.is_div) begin
				x_q <= a[W-1] ? (~a + 1'b1) : a;
				y_q <= b[W-1] ? (~b + 1'b1) : b;
			end else begin
				x_q <= a;
				y_q <= b;
			end
			negq_q <= a[W-1] ^ b[W-1];
			negr_q <= a[W-1];
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (is_div_q) begin
				if (!trial[W]) begin
					r_q <= trial[W-1:0];
					x_q <= {x_q[W-2:0], 1'b1};
				end else begin
					r_q <= {r_q[W-2:0], x_q[W-1]};
					x_q <= {x_q[W-2:0], 1'b0};
				end
			end else begin
				if (x_q[0]) begin
					acc_q <= acc_q + y_q;
				end
				x_q <= x_q >> 1;
				y_q <= y_q << 1;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
	assign quo  = negq_q ? (~x_q + 1'b1) : x_q;
	assign rem  = negr_q ? (~r_q + 1'b1) : r_q;

endmodule

@@ sv/forth_data_stack_unit.sv @@
// Forth data stack with ALU. Raise start for one cycle while busy is low; the
// word runs and its result appears once, for a single cycle with strobe high,
// and must be captured then since there is no back-pressure. The stack lives
// in a single-port-read RAM, so a word reads its operands with one RAM read per
// operand taken, waits for the last read to land, executes, writes one entry
// per entry pushed and then reads the new top. Multiply, divide and mod run
// between execute and write in the bit-serial multiply/divide unit. A word
// rejected for underflow or overflow goes straight to the top read, and one
// with a zero divisor skips the unit and drops the divisor. busy drops in the
// cycle strobe is high, so the next word may start then.
module forth_data_stack_unit
	import fds_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [CMD_W-1:0]   cmd,
	input  logic signed [31:0] literal,
	output logic               strobe,
	output logic [1:0]         status,
	output logic signed [31:0] popped_value,
	output logic signed [31:0] tos_value,
	output logic               top_valid,
	output logic [6:0]         depth_after,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	`include "forth_data_stack_unit_macros.svh"

	localparam int W     = WORD_WIDTH;
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int LW    = (CNT_W > LIMIT_W ? CNT_W : LIMIT_W) + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_RDLAST, S_EXEC, S_MDU, S_WRITE, S_TOPRD, S_TOPWAIT
	} state_t;

	state_t             state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]   count_q;
	logic [CMD_W-1:0]   cmd_q;
	dec_t               dec_q;
	logic [W-1:0]       lit_q;
	logic [W-1:0]       t_q [6];
	logic [W-1:0]       p_q [6];
	logic [2:0]         ridx_q;
	logic [2:0]         widx_q;
	logic               cap_vld_s1;
	logic [2:0]         cap_idx_s1;
	logic [1:0]         status_q;
	logic [W-1:0]       popped_q;
	logic [W-1:0]       top_q;
	logic               strobe_q;

	dec_t               dec_in;
	logic [LW-1:0]      lim_eff;
	logic [LW-1:0]      after_in;
	logic [CNT_W-1:0]   base;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [W-1:0]       ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [W-1:0]       ram_rdata;
	mdu_ctl_t           mdu_ctl;
	logic               mdu_done;
	logic [W-1:0]       mdu_prod;
	logic [W-1:0]       mdu_quo;
	logic [W-1:0]       mdu_rem;
	logic               cfg_wr;
	logic [W-1:0]       true_w;

	assign true_w  = '1;
	assign dec_in  = decode(cmd);
	assign lim_eff = (LW'(limit_q) < LW'(STACK_DEPTH)) ? LW'(limit_q) : LW'(STACK_DEPTH);
	assign after_in = LW'(count_q) - LW'(dec_in.pops) + LW'(dec_in.npush);
	assign base    = count_q - CNT_W'(dec_q.pops);

	// apb register
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STACK_LIMIT) ? 32'(limit_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr && paddr[2] == REG_STACK_LIMIT) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// ram control
	always_comb begin
		ram_we    = (state_q == S_WRITE);
		ram_waddr = AW'(base + CNT_W'(widx_q));
		ram_wdata = p_q[widx_q];
		ram_re    = (state_q == S_READ) || (state_q == S_TOPRD);
		if (state_q == S_READ) begin
			ram_raddr = AW'(count_q - 1'b1 - CNT_W'(ridx_q));
		end else begin
			ram_raddr = AW'(count_q - 1'b1);
		end
	end

	assign mdu_ctl.start  = (state_q == S_EXEC) && dec_q.is_md && !(dec_q.is_div && t_q[0] == '0);
	assign mdu_ctl.is_div = dec_q.is_div;

	fds_ram #(.DEPTH(STACK_DEPTH), .W(W)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fds_mdu #(.W(W)) u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mdu_ctl),
		.a      (t_q[1]),
		.b      (t_q[0]),
		.done   (mdu_done),
		.prod   (mdu_prod),
		.quo    (mdu_quo),
		.rem    (mdu_rem)
	);

	// operand capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_vld_s1 <= 1'b0;
		end else begin
			cap_vld_s1 <= (state_q == S_READ);
		end
	end

	always_ff @(posedge clk) begin
		cap_idx_s1 <= ridx_q;
		if (cap_vld_s1) begin
			t_q[cap_idx_s1] <= ram_rdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
			ridx_q   <= '0;
			widx_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q    <= cmd;
						dec_q    <= dec_in;
						lit_q    <= W'($unsigned(literal));
						popped_q <= '0;
						status_q <= ST_OK;
						ridx_q   <= '0;
						widx_q   <= '0;
						if (dec_in.known && CNT_W'(dec_in.need) > count_q) begin
							status_q <= ST_UNDER;
							state_q  <= S_TOPRD;
						end else if (dec_in.known && dec_in.npush > dec_in.pops
								&& after_in > lim_eff) begin
							status_q <= ST_OVER;
							state_q  <= S_TOPRD;
						end else if (dec_in.known && dec_in.need != 3'd0) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_READ: begin
					ridx_q <= ridx_q + 1'b1;
					if (ridx_q == dec_q.need - 1'b1) begin
						state_q <= S_RDLAST;
					end
				end
				S_RDLAST: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (!dec_q.known) begin
						state_q <= S_TOPRD;
					end else if (dec_q.is_div && t_q[0] == '0) begin
						status_q <= ST_DIVZ;
						count_q  <= count_q - 1'b1;
						state_q  <= S_TOPRD;
					end else if (dec_q.is_md) begin
						state_q <= S_MDU;
					end else begin
						case (cmd_q)
							CMD_PUSH:  p_q[0] <= lit_q;
							CMD_DUP:   p_q[0] <= t_q[0];
							CMD_SWAP:  begin p_q[0] <= t_q[0]; p_q[1] <= t_q[1]; end
							CMD_OVER:  p_q[0] <= t_q[1];
							CMD_ROT: begin
								p_q[0] <= t_q[1]; p_q[1] <= t_q[0]; p_q[2] <= t_q[2];
							end
							CMD_2SWAP: begin
								p_q[0] <= t_q[1]; p_q[1] <= t_q[0];
								p_q[2] <= t_q[3]; p_q[3] <= t_q[2];
							end
							CMD_2DUP:  begin p_q[0] <= t_q[1]; p_q[1] <= t_q[0]; end
							CMD_2OVER: begin p_q[0] <= t_q[3]; p_q[1] <= t_q[2]; end
							CMD_2ROT: begin
								p_q[0] <= t_q[3]; p_q[1] <= t_q[2]; p_q[2] <= t_q[1];
								p_q[3] <= t_q[0]; p_q[4] <= t_q[5]; p_q[5] <= t_q[4];
							end
							CMD_ADD:   p_q[0] <= t_q[1] + t_q[0];
							CMD_SUB:   p_q[0] <= t_q[1] - t_q[0];
							CMD_EQ:    p_q[0] <= (t_q[1] == t_q[0]) ? true_w : '0;
							CMD_LT:    p_q[0] <= ($signed(t_q[1]) < $signed(t_q[0])) ? true_w : '0;
							CMD_GT:    p_q[0] <= ($signed(t_q[1]) > $signed(t_q[0])) ? true_w : '0;
							CMD_INV:   p_q[0] <= ~t_q[0];
							CMD_AND:   p_q[0] <= (t_q[0] != '0 && t_q[1] != '0) ? true_w : '0;
							CMD_OR:    p_q[0] <= (t_q[0] != '0 || t_q[1] != '0) ? true_w : '0;
							CMD_DEPTH: p_q[0] <= W'(count_q);
							default:   p_q[0] <= '0;
						endcase
						if (cmd_q == CMD_DROP) begin
							popped_q <= t_q[0];
						end
						if (dec_q.npush != 3'd0) begin
							state_q <= S_WRITE;
						end else begin
							count_q <= base;
							state_q <= S_TOPRD;
						end
					end
				end
				S_MDU: begin
					if (mdu_done) begin
						case (cmd_q)
							CMD_MUL:    p_q[0] <= mdu_prod;
							CMD_DIV:    p_q[0] <= mdu_quo;
							CMD_MOD:    p_q[0] <= mdu_rem;
							default:    begin p_q[0] <= mdu_rem; p_q[1] <= mdu_quo; end
						endcase
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					widx_q <= widx_q + 1'b1;
					if (widx_q == dec_q.npush - 1'b1) begin
						count_q <= base + CNT_W'(dec_q.npush);
						state_q <= S_TOPRD;
					end
				end
				S_TOPRD: begin
					state_q <= S_TOPWAIT;
				end
				S_TOPWAIT: begin
					top_q    <= (count_q != '0) ? ram_rdata : '0;
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign strobe       = strobe_q;
	assign status       = status_q;
	assign popped_value = 32'(popped_q);
	assign tos_value    = 32'(top_q);
	assign top_valid    = (count_q != '0);
	assign depth_after  = 7'(count_q);

	`FDS_ASSERT_NOW(a_count_in_range, strobe, count_q <= CNT_W'(STACK_DEPTH), "stack count above capacity")
	`FDS_ASSERT_NEXT(a_start_goes_busy, start && !busy, busy, "accepted request did not start")
	`FDS_ASSERT_NOW(a_mdu_done_in_wait, mdu_done, state_q == S_MDU, "mdu finished outside its wait state")
	`FDS_ASSERT_NOW(a_empty_top_zero, strobe && !top_valid, top_q == '0, "empty stack reports nonzero top")

endmodule

@@ verif/tb.sv @@
module tb;
	import fds_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [CMD_W-1:0] code;
		logic [31:0]      lit;
	} request_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] popped;
		logic [31:0] top;
		logic        valid;
		logic [6:0]  depth;
	} outcome_t;

	logic clk = 1'b0, arst_n = 1'b0;
	logic start = 1'b0, busy;
	logic [CMD_W-1:0] cmd = '0;
	logic signed [31:0] literal = '0;
	logic strobe, top_valid;
	logic [1:0] status;
	logic signed [31:0] popped_value, tos_value;
	logic [6:0] depth_after;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0, prdata;
	logic pready;

	forth_data_stack_unit dut (.*);

	request_t pending[$];
	outcome_t expected_q[$];
	logic [31:0] words[STACK_DEPTH_DEF];
	int unsigned used = 0;
	int unsigned limit_reg = 64;
	int errors = 0;
	int gap = 0;
	bit quiet = 1'b0;
	longint cycles = 0;

	initial forever #5 clk = ~clk;

	task automatic report(input string what);
		errors++;
		$display("mismatch at cycle %0d: %s", cycles, what);
	endtask

	function automatic logic [31:0] peek(input int unsigned i);
		return (i < used) ? words[used - 1 - i] : 32'd0;
	endfunction

	// run one word on the model stack and return the expected response
	function automatic outcome_t execute_word(input logic [CMD_W-1:0] c, input logic [31:0] lit);
		outcome_t o;
		logic [31:0] t[6];
		logic [31:0] p[6];
		logic signed [31:0] s0, s1;
		logic [31:0] q, r, popv;
		int unsigned need, pops, npush, after, lim;
		bit known, div;
		for (int i = 0; i < 6; i++) t[i] = peek(i);
		s0 = t[0];
		s1 = t[1];
		need = 0; pops = 0; npush = 0; known = 1; div = 0; popv = '0;
		q = '0; r = '0;
		if (s0 == -1) begin
			q = -t[1];
		end else if (s0 != 0) begin
			q = s1 / s0;
			r = s1 % s0;
		end
		case (c)
			CMD_PUSH:   begin p[0] = lit; npush = 1; end
			CMD_DROP:   begin need = 1; pops = 1; end
			CMD_DUP:    begin need = 1; p[0] = t[0]; npush = 1; end
			CMD_SWAP:   begin need = 2; pops = 2; p[0] = t[0]; p[1] = t[1]; npush = 2; end
			CMD_OVER:   begin need = 2; p[0] = t[1]; npush = 1; end
			CMD_ROT: begin
				need = 3; pops = 3; p[0] = t[1]; p[1] = t[0]; p[2] = t[2]; npush = 3;
			end
			CMD_2SWAP: begin
				need = 4; pops = 4; npush = 4;
				p[0] = t[1]; p[1] = t[0]; p[2] = t[3]; p[3] = t[2];
			end
			CMD_2DUP:   begin need = 2; p[0] = t[1]; p[1] = t[0]; npush = 2; end
			CMD_2OVER:  begin need = 4; p[0] = t[3]; p[1] = t[2]; npush = 2; end
			CMD_2DROP:  begin need = 2; pops = 2; end
			CMD_2ROT: begin
				need = 6; pops = 6; npush = 6;
				p[0] = t[3]; p[1] = t[2]; p[2] = t[1]; p[3] = t[0]; p[4] = t[5]; p[5] = t[4];
			end
			CMD_ADD:    begin need = 2; pops = 2; p[0] = t[1] + t[0]; npush = 1; end
			CMD_SUB:    begin need = 2; pops = 2; p[0] = t[1] - t[0]; npush = 1; end
			CMD_MUL:    begin need = 2; pops = 2; p[0] = t[1] * t[0]; npush = 1; end
			CMD_DIV:    begin need = 2; pops = 2; div = 1; p[0] = q; npush = 1; end
			CMD_MOD:    begin need = 2; pops = 2; div = 1; p[0] = r; npush = 1; end
			CMD_DIVMOD: begin need = 2; pops = 2; div = 1; p[0] = r; p[1] = q; npush = 2; end
			CMD_EQ:     begin need = 2; pops = 2; p[0] = {32{s1 == s0}}; npush = 1; end
			CMD_LT:     begin need = 2; pops = 2; p[0] = {32{s1 < s0}}; npush = 1; end
			CMD_GT:     begin need = 2; pops = 2; p[0] = {32{s1 > s0}}; npush = 1; end
			CMD_INV:    begin need = 1; pops = 1; p[0] = ~t[0]; npush = 1; end
			CMD_AND: begin
				need = 2; pops = 2; p[0] = {32{t[0] != 0 && t[1] != 0}}; npush = 1;
			end
			CMD_OR: begin
				need = 2; pops = 2; p[0] = {32{t[0] != 0 || t[1] != 0}}; npush = 1;
			end
			CMD_DEPTH:  begin p[0] = used; npush = 1; end
			default:    known = 0;
		endcase
		o.status = ST_OK;
		if (known) begin
			lim = (limit_reg < STACK_DEPTH_DEF) ? limit_reg : STACK_DEPTH_DEF;
			after = used - pops + npush;
			if (used < need) begin
				o.status = ST_UNDER;
			end else if (div && t[0] == 0) begin
				o.status = ST_DIVZ;
				used--;
			end else if (after > used && after > lim) begin
				o.status = ST_OVER;
			end else begin
				if (c == CMD_DROP) popv = t[0];
				used -= pops;
				for (int i = 0; i < npush; i++) begin
					words[used] = p[i];
					used++;
				end
			end
		end
		o.popped = popv;
		o.top = peek(0);
		o.valid = used > 0;
		o.depth = used[6:0];
		return o;
	endfunction

	// driver
	always @(posedge clk) begin
		request_t nx;
		logic want;
		cycles++;
		want = start;
		if (start && !busy) begin
			expected_q.push_back(execute_word(cmd, literal));
			want = 1'b0;
			if (!quiet && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 10);
		end
		if (!want && arst_n) begin
			if (gap > 0) begin
				gap--;
			end else if (pending.size() > 0) begin
				nx = pending.pop_front();
				cmd <= nx.code;
				literal <= nx.lit;
				want = 1'b1;
			end
		end
		start <= want;
	end

	// monitor
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && strobe) begin
			if (expected_q.size() == 0) begin
				report("response with nothing outstanding");
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status)
					report($sformatf("status %0d, want %0d", status, e.status));
				if (popped_value !== e.popped)
					report($sformatf("popped_value %0h, want %0h", popped_value, e.popped));
				if (tos_value !== e.top)
					report($sformatf("tos_value %0h, want %0h", tos_value, e.top));
				if (top_valid !== e.valid)
					report($sformatf("top_valid %0b, want %0b", top_valid, e.valid));
				if (depth_after !== e.depth)
					report($sformatf("depth_after %0d, want %0d", depth_after, e.depth));
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 1000000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic add_req(input logic [CMD_W-1:0] c, input logic [31:0] v = 32'd0);
		request_t rq;
		rq.code = c;
		rq.lit = v;
		pending.push_back(rq);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			3: return 32'd0;
			4, 5: return $urandom_range(0, 40) - 20;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_random(input int n, input int push_pct);
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 99) < push_pct) begin
				add_req(CMD_PUSH, pick_value());
				k++;
			end else if ($urandom_range(0, 24) == 0) begin
				add_req(CMD_W'($urandom_range(24, 31)), $urandom);
			end else begin
				add_req(CMD_W'($urandom_range(1, 23)), $urandom);
				k++;
			end
		end
	endtask

	task automatic drain();
		while (pending.size() > 0 || start || expected_q.size() > 0) @(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic set_limit(input int unsigned v);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= '0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		limit_reg = v & 32'h7f;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed words, extremes and error paths
		add_req(CMD_DROP);
		add_req(CMD_PUSH, 32'h7fff_ffff);
		add_req(CMD_PUSH, 32'h8000_0000);
		add_req(CMD_ADD);
		add_req(CMD_PUSH, 32'h8000_0000);
		add_req(CMD_PUSH, 32'hffff_ffff);
		add_req(CMD_DIVMOD);
		add_req(CMD_PUSH, 32'd0);
		add_req(CMD_DIV);
		add_req(CMD_PUSH, -32'sd7);
		add_req(CMD_PUSH, 32'd2);
		add_req(CMD_MOD);
		add_req(CMD_DUP);
		add_req(CMD_SWAP);
		add_req(CMD_OVER);
		add_req(CMD_ROT);
		add_req(CMD_2DUP);
		add_req(CMD_2SWAP);
		add_req(CMD_2OVER);
		add_req(CMD_2ROT);
		add_req(CMD_2DROP);
		add_req(CMD_SUB);
		add_req(CMD_MUL);
		add_req(CMD_EQ);
		add_req(CMD_LT);
		add_req(CMD_GT);
		add_req(CMD_INV);
		add_req(CMD_AND);
		add_req(CMD_OR);
		add_req(CMD_DEPTH);
		add_req(5'd31, 32'h1234_5678);
		drain();
		add_random(400, 45);
		drain();
		set_limit(6);
		add_random(200, 50);
		drain();
		set_limit(0);
		add_random(40, 40);
		drain();
		set_limit(127);
		add_random(300, 70);
		drain();
		set_limit(1);
		add_random(100, 40);
		drain();
		set_limit(64);
		quiet = 1'b1;
		add_random(400, 45);
		drain();
		repeat (50) @(posedge clk);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
